>>> rtl/core/tsp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the turtle step engine.
package tsp_pkg;

    // Angle constants in whole degrees
    localparam logic [8:0] DEG_FULL    = 9'd360;
    localparam logic [8:0] DEG_HALF    = 9'd180;
    localparam logic [8:0] DEG_QUARTER = 9'd90;

    // Configuration port
    localparam int         CFG_IDX_W  = 2;
    localparam int         CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_Y = 2'd1;
    localparam logic [CFG_DATA_W-1:0] HOME_X_RESET = 12'd320;
    localparam logic [CFG_DATA_W-1:0] HOME_Y_RESET = 12'd240;

    // Width of one move step in Q16.16 (magnitude never exceeds 2^27)
    localparam int DELTA_W = 29;

    // Sine evaluation constants in Q30
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    typedef enum logic [1:0] {
        ACT_TURN    = 2'd0,
        ACT_FORWARD = 2'd1,
        ACT_JUMP    = 2'd2,
        ACT_CLEAR   = 2'd3
    } action_t;

    // Command held in the input register; turn already reduced to 0..359
    typedef struct packed {
        action_t            action;
        logic signed [19:0] distance;
        logic [8:0]         turn_mod;
    } cmd_t;

    // One result item
    typedef struct packed {
        logic               line_valid;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic               run_start;
        logic               run_closed;
        logic [8:0]         heading;
    } res_t;

    // Sine of q degrees (q in 0..90) in Q30, odd Taylor series to x^15.
    // Only evaluated at elaboration to build the quarter-wave table.
    function automatic logic [63:0] sin_q30(input int unsigned q);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        longint      s;
        if (q == 0) return 64'd0;
        if (q >= 90) return ONE_Q30;
        x  = (64'(q) * PI_Q30 + 64'd90) / 64'd180;
        x2 = (x * x + (64'd1 << 29)) >> 30;
        t  = x;
        s  = longint'(x);
        t  = ((t * x2) >> 30) / 64'd6;
        s  = s - longint'(t);
        t  = ((t * x2) >> 30) / 64'd20;
        s  = s + longint'(t);
        t  = ((t * x2) >> 30) / 64'd42;
        s  = s - longint'(t);
        t  = ((t * x2) >> 30) / 64'd72;
        s  = s + longint'(t);
        t  = ((t * x2) >> 30) / 64'd110;
        s  = s - longint'(t);
        t  = ((t * x2) >> 30) / 64'd156;
        s  = s + longint'(t);
        t  = ((t * x2) >> 30) / 64'd210;
        s  = s - longint'(t);
        if (s < 0) s = 0;
        if (s > longint'(ONE_Q30)) s = longint'(ONE_Q30);
        return 64'(s);
    endfunction

    // Quarter-wave sine rounded half up to frac_bits fraction bits
    function automatic logic [63:0] sin_round(input int unsigned q, input int frac_bits);
        logic [63:0] s;
        s = sin_q30(q);
        return (s + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
    endfunction

    // Q16.16 position plus step, clamped to the signed 32-bit range
    function automatic logic [31:0] sat_add(input logic [31:0] a,
                                            input logic [DELTA_W-1:0] d);
        logic [33:0] s;
        s = {{2{a[31]}}, a} + {{(34 - DELTA_W){d[DELTA_W-1]}}, d};
        if (s[33:31] == 3'b000 || s[33:31] == 3'b111) return s[31:0];
        else if (s[33]) return 32'h8000_0000;
        else return 32'h7fff_ffff;
    endfunction

    // Q16.16 to whole pixels, truncated toward zero
    function automatic logic [15:0] trunc_px(input logic [31:0] v);
        if (v[31] && (v[15:0] != 16'd0)) return v[31:16] + 16'd1;
        else return v[31:16];
    endfunction

endpackage

>>> rtl/core/tsp_in_stage.sv
`timescale 1ns / 1ps
// Input register of the turtle step engine, with the turn reduced modulo 360.
module tsp_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic signed [19:0] distance,
    input  logic signed [15:0] turn_degrees,
    output logic               cmd_valid,
    output tsp_pkg::cmd_t      cmd,
    input  logic               cmd_take
);

    // Offset 92*360 makes every turn positive without changing it mod 360
    localparam logic [17:0] TURN_OFFSET = 18'd33120;
    // floor(2^24 / 360); quotient is at most one low, fixed by one compare
    localparam logic [15:0] RECIP_360   = 16'd46603;

    logic          valid_reg;
    tsp_pkg::cmd_t cmd_reg;
    tsp_pkg::cmd_t cmd_next;

    logic [17:0] turn_sum;
    logic [16:0] turn_off;
    logic [32:0] quot_prod;
    logic [7:0]  quot;
    logic [16:0] quot_mul;
    logic [16:0] rem;
    logic [16:0] rem_fix;

    // Turn reduction: reciprocal multiply, then one correction step
    assign turn_sum  = {{2{turn_degrees[15]}}, turn_degrees} + TURN_OFFSET;
    assign turn_off  = turn_sum[16:0];
    assign quot_prod = {16'd0, turn_off} * {17'd0, RECIP_360};
    assign quot      = quot_prod[31:24];
    assign quot_mul  = {9'd0, quot} * {8'd0, tsp_pkg::DEG_FULL};
    assign rem       = turn_off - quot_mul;
    assign rem_fix   = (rem >= {8'd0, tsp_pkg::DEG_FULL}) ?
                       (rem - {8'd0, tsp_pkg::DEG_FULL}) : rem;

    always_comb
    begin
        cmd_next.action   = tsp_pkg::action_t'(action);
        cmd_next.distance = distance;
        cmd_next.turn_mod = rem_fix[8:0];
    end

    // Register empties as the core takes it, so a new transfer fits each cycle while the core keeps taking
    assign in_ready = !valid_reg || cmd_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

>>> rtl/core/tsp_trig.sv
`timescale 1ns / 1ps
// Sine and cosine of a whole-degree heading from a quarter-wave table.
module tsp_trig #(
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic [8:0]                       heading,
    output logic signed [TRIG_FRAC_BITS+1:0] sin_val,
    output logic signed [TRIG_FRAC_BITS+1:0] cos_val
);

    localparam int TW = TRIG_FRAC_BITS + 2;

    typedef struct packed {
        logic       neg;
        logic [6:0] idx;
    } fold_t;

    logic [TRIG_FRAC_BITS:0] quarter_tab [0:90];

    // Constant table, one entry per degree of the first quadrant
    genvar gi;
    generate
        for (gi = 0; gi <= 90; gi++)
        begin : g_tab
            localparam logic [63:0] ENTRY = tsp_pkg::sin_round(gi, TRIG_FRAC_BITS);
            assign quarter_tab[gi] = ENTRY[TRIG_FRAC_BITS:0];
        end
    endgenerate

    // Fold an angle in 0..359 onto the first quadrant
    function automatic fold_t fold(input logic [8:0] d);
        fold_t      f;
        logic [8:0] h;
        f.neg = (d >= tsp_pkg::DEG_HALF);
        h     = f.neg ? (d - tsp_pkg::DEG_HALF) : d;
        h     = (h > tsp_pkg::DEG_QUARTER) ? (tsp_pkg::DEG_HALF - h) : h;
        f.idx = h[6:0];
        return f;
    endfunction

    logic [9:0]              cos_sum;
    logic [8:0]              cos_ang;
    fold_t                   sin_f;
    fold_t                   cos_f;
    logic [TW-1:0]           sin_mag;
    logic [TW-1:0]           cos_mag;

    // cos(h) = sin(h + 90)
    assign cos_sum = {1'b0, heading} + {1'b0, tsp_pkg::DEG_QUARTER};
    assign cos_ang = (cos_sum >= {1'b0, tsp_pkg::DEG_FULL}) ?
                     9'(cos_sum - {1'b0, tsp_pkg::DEG_FULL}) : cos_sum[8:0];

    assign sin_f   = fold(heading);
    assign cos_f   = fold(cos_ang);
    assign sin_mag = {1'b0, quarter_tab[sin_f.idx]};
    assign cos_mag = {1'b0, quarter_tab[cos_f.idx]};

    assign sin_val = sin_f.neg ? $signed(-sin_mag) : $signed(sin_mag);
    assign cos_val = cos_f.neg ? $signed(-cos_mag) : $signed(cos_mag);

endmodule

>>> rtl/core/tsp_move.sv
`timescale 1ns / 1ps
// Distance times trig value, rounded half away from zero to Q16.16.
module tsp_move #(
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic signed [19:0]               distance,
    input  logic signed [TRIG_FRAC_BITS+1:0] trig,
    output logic [tsp_pkg::DELTA_W-1:0]      delta
);

    localparam int PW = 20 + TRIG_FRAC_BITS + 2;
    localparam int SH = TRIG_FRAC_BITS - 8;

    logic signed [PW-1:0] prod;
    logic [PW-1:0]        mag;
    logic [PW-1:0]        mag_r;
    logic                 neg;

    // Product is Q(8 + TRIG_FRAC_BITS)
    assign prod = PW'(distance) * PW'(trig);
    assign neg  = prod[PW-1];
    assign mag  = neg ? PW'(-prod) : PW'(prod);

    // Round the magnitude, then put the sign back
    generate
        if (SH > 0)
        begin : g_round
            localparam logic [PW-1:0] HALF = PW'(1) << (SH - 1);
            assign mag_r = (mag + HALF) >> SH;
        end
        else
        begin : g_exact
            assign mag_r = mag;
        end
    endgenerate

    assign delta = neg ? (~mag_r[tsp_pkg::DELTA_W-1:0] + 1'b1)
                       : mag_r[tsp_pkg::DELTA_W-1:0];

endmodule

>>> rtl/core/turtle_heading_position_step.sv
`timescale 1ns / 1ps
// Top level of the turtle step engine: state, move logic and result register.
//
// Each accepted command (turn, forward, jump, clear) gives exactly one result
// item. The engine takes one command per clock while results are taken. A
// command is held in the input register, with the turn reduced modulo 360 on
// its way in, then passes through the move logic into the result register,
// from which its result is offered. The position is updated combinationally
// from the registered state:
// a distance-times-trig multiply, rounding, and a saturating Q16.16 add, so
// each command sees the position left by the one before. Sine and cosine of
// the current heading are kept in registers and refreshed from a constant
// quarter-wave table whenever the heading changes. A stalled result holds in
// the result register while the input register, if empty, still takes one more command.
// home_x and home_y take effect at the next clear; writes are meant
// for idle periods only.
module turtle_heading_position_step #(
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic               clk,
    input  logic               rst_n,
    // Configuration writes
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [11:0]        cfg_data,
    // Command channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic signed [19:0] distance,
    input  logic signed [15:0] turn_degrees,
    // Result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic               line_valid,
    output logic signed [15:0] start_x,
    output logic signed [15:0] start_y,
    output logic signed [15:0] end_x,
    output logic signed [15:0] end_y,
    output logic               run_start,
    output logic               run_closed,
    output logic [8:0]         heading
);

    localparam int TW = TRIG_FRAC_BITS + 2;
    localparam logic [TW-1:0] TRIG_ONE = TW'(1) << TRIG_FRAC_BITS;

    logic          cmd_valid;
    tsp_pkg::cmd_t cmd;
    logic          core_ready;
    logic          advance;

    logic [11:0]   home_x_reg;
    logic [11:0]   home_y_reg;
    logic [8:0]    heading_reg;
    logic [8:0]    heading_next;
    logic [31:0]   pos_x_reg;
    logic [31:0]   pos_x_next;
    logic [31:0]   pos_y_reg;
    logic [31:0]   pos_y_next;
    logic          run_open_reg;
    logic          run_open_next;
    logic signed [TW-1:0] sin_reg;
    logic signed [TW-1:0] cos_reg;
    logic signed [TW-1:0] sin_next;
    logic signed [TW-1:0] cos_next;

    logic [tsp_pkg::DELTA_W-1:0] dx;
    logic [tsp_pkg::DELTA_W-1:0] dy;
    logic [31:0]   moved_x;
    logic [31:0]   moved_y;
    logic [9:0]    head_sum;
    logic [8:0]    head_wrap;

    logic          out_valid_reg;
    tsp_pkg::res_t res_reg;
    tsp_pkg::res_t res_next;

    tsp_in_stage u_in_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .distance     (distance),
        .turn_degrees (turn_degrees),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_take     (advance)
    );

    // Result register frees up when empty or when its transfer completes
    assign core_ready = !out_valid_reg || out_ready;
    assign advance    = cmd_valid && core_ready;

    // Step sizes from the stored trig values
    tsp_move #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_move_x (
        .distance (cmd.distance),
        .trig     (cos_reg),
        .delta    (dx)
    );

    tsp_move #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_move_y (
        .distance (cmd.distance),
        .trig     (sin_reg),
        .delta    (dy)
    );

    assign moved_x = tsp_pkg::sat_add(pos_x_reg, dx);
    assign moved_y = tsp_pkg::sat_add(pos_y_reg, dy);

    // New heading after a turn
    assign head_sum  = {1'b0, heading_reg} + {1'b0, cmd.turn_mod};
    assign head_wrap = (head_sum >= {1'b0, tsp_pkg::DEG_FULL}) ?
                       9'(head_sum - {1'b0, tsp_pkg::DEG_FULL}) : head_sum[8:0];

    // Command execution
    always_comb
    begin
        heading_next  = heading_reg;
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        run_open_next = run_open_reg;
        res_next      = '0;
        if (advance)
        begin
            unique case (cmd.action)
                tsp_pkg::ACT_TURN:
                begin
                    heading_next = head_wrap;
                end
                tsp_pkg::ACT_FORWARD:
                begin
                    res_next.line_valid = 1'b1;
                    res_next.start_x    = tsp_pkg::trunc_px(pos_x_reg);
                    res_next.start_y    = tsp_pkg::trunc_px(pos_y_reg);
                    res_next.end_x      = tsp_pkg::trunc_px(moved_x);
                    res_next.end_y      = tsp_pkg::trunc_px(moved_y);
                    res_next.run_start  = !run_open_reg;
                    run_open_next       = 1'b1;
                    pos_x_next          = moved_x;
                    pos_y_next          = moved_y;
                end
                tsp_pkg::ACT_JUMP:
                begin
                    res_next.run_closed = run_open_reg;
                    run_open_next       = 1'b0;
                    pos_x_next          = moved_x;
                    pos_y_next          = moved_y;
                end
                tsp_pkg::ACT_CLEAR:
                begin
                    res_next.run_closed = run_open_reg;
                    run_open_next       = 1'b0;
                    pos_x_next          = {4'd0, home_x_reg, 16'd0};
                    pos_y_next          = {4'd0, home_y_reg, 16'd0};
                end
                default:
                begin
                    heading_next = heading_reg;
                end
            endcase
        end
        res_next.heading = heading_next;
    end

    // Trig of the heading the next command will use
    tsp_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig (
        .heading (heading_next),
        .sin_val (sin_next),
        .cos_val (cos_next)
    );

    // Home registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            home_x_reg <= tsp_pkg::HOME_X_RESET;
            home_y_reg <= tsp_pkg::HOME_Y_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tsp_pkg::REG_HOME_X: home_x_reg <= cfg_data;
                tsp_pkg::REG_HOME_Y: home_y_reg <= cfg_data;
                default:             home_y_reg <= home_y_reg;
            endcase
        end
    end

    // Turtle state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heading_reg  <= '0;
            pos_x_reg    <= {4'd0, tsp_pkg::HOME_X_RESET, 16'd0};
            pos_y_reg    <= {4'd0, tsp_pkg::HOME_Y_RESET, 16'd0};
            run_open_reg <= 1'b0;
            sin_reg      <= '0;
            cos_reg      <= TRIG_ONE;
        end
        else
        begin
            heading_reg  <= heading_next;
            pos_x_reg    <= pos_x_next;
            pos_y_reg    <= pos_y_next;
            run_open_reg <= run_open_next;
            sin_reg      <= sin_next;
            cos_reg      <= cos_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (core_ready)
        begin
            out_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign line_valid = res_reg.line_valid;
    assign start_x    = res_reg.start_x;
    assign start_y    = res_reg.start_y;
    assign end_x      = res_reg.end_x;
    assign end_y      = res_reg.end_y;
    assign run_start  = res_reg.run_start;
    assign run_closed = res_reg.run_closed;
    assign heading    = res_reg.heading;

    // A segment never closes a run in the same result
    a_draw_not_closed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(line_valid && run_closed))
        else $error("segment result also reports a closed run");

    // Run start only on drawn segments
    a_start_on_line: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && run_start) |-> line_valid)
        else $error("run start without a segment");

    // Coordinates are zero in non-drawing results
    a_coords_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !line_valid) |->
        (start_x == 16'sd0 && start_y == 16'sd0 && end_x == 16'sd0 && end_y == 16'sd0))
        else $error("coordinates set in a non-drawing result");

    // Heading stays inside one turn
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        heading_reg < tsp_pkg::DEG_FULL)
        else $error("heading out of range");

    // A forward command leaves a run open
    a_forward_opens: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && cmd.action == tsp_pkg::ACT_FORWARD) |=> run_open_reg)
        else $error("run not open after a forward command");

endmodule
